// ===== rtl/cht_pkg.sv =====
`timescale 1ns / 1ps
package cht_pkg;

   localparam int KEY_W = 31;
   localparam int H_W = 17;
   localparam int KICK_W = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_NOP = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_MULT_ONE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_ONE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME_ONE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT_TWO = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_TWO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIME_TWO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_KICKS = 3'd6;

   typedef struct packed {
      logic [1:0] kind;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic found;
      logic status;
      logic [KEY_W-1:0] leftover_key;
   } rsp_type;

   typedef struct packed {
      logic [H_W-1:0] mult;
      logic [H_W-1:0] offset;
      logic [H_W-1:0] prime;
   } hash_cfg_type;

endpackage

// ===== rtl/cuckoo_hash_table.sv =====
`timescale 1ns / 1ps
// Cuckoo hash set of 31-bit keys held in one table of TABLE_SIZE slots.
// An item on req_ (kind, key) is taken when req_valid is high and req_stall low.
// kind 0 inserts, 1 looks up, 2 removes; kind 3 does nothing and answers zero.
// Each item gives exactly one result on rsp_, held until rsp_stall is low.
// Each hash runs in the shared bit-serial remainder unit (start, add, remainder
// steps, hand-over); the steps are skipped when its prime is zero and TABLE_SIZE
// is a power of two, and a pass dividing by TABLE_SIZE is used when it is not.
// Both candidates are hashed before any slot is read; a lookup always reads both
// slots, a remove that hits the first slot or an insert that finds it empty ends
// there, and an insert makes up to max_kicks+1 displacement rounds. One item is
// worked at a time; req_stall is high meanwhile and while a result waits to be
// taken. Once the result is taken, S_WAITR returns to S_IDLE for the next item.
// After reset a clearing pass walks all TABLE_SIZE slots one slot a cycle, taking
// no item. Registers reset to their default values; the user must write them
// through csr_ (valid/ready, index, data) only when idle, as it is not enforced.
module cuckoo_hash_table #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  cht_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output cht_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [cht_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cht_pkg::CSR_DATA_W-1:0] csr_data
);
   localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int KW = cht_pkg::KEY_W;

   typedef enum logic [10:0] {
      S_CLEAR = 11'b00000000001,
      S_IDLE  = 11'b00000000010,
      S_H1    = 11'b00000000100,
      S_RD1   = 11'b00000001000,
      S_CHK1  = 11'b00000010000,
      S_H2    = 11'b00000100000,
      S_RD2   = 11'b00001000000,
      S_CHK2  = 11'b00010000000,
      S_RESP  = 11'b00100000000,
      S_HSTART= 11'b01000000000,
      S_WAITR = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   cht_pkg::hash_cfg_type cfg1_ff, cfg2_ff;
   logic [cht_pkg::KICK_W-1:0] kicks_ff;
   logic [1:0] kind_ff, kind_in;
   logic [KW-1:0] cur_ff, cur_in;
   logic [cht_pkg::KICK_W:0] round_ff, round_in;
   logic [IDX_W-1:0] i1_ff, i1_in, i2_ff, i2_in;
   logic hit1_ff, hit1_in;
   logic [IDX_W:0] clr_ff, clr_in;
   cht_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [KW:0] mem [TABLE_SIZE];
   logic [KW:0] rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KW:0] wr_data;

   logic h_start, h_done;
   logic h_sel_ff, h_sel_in;
   cht_pkg::hash_cfg_type h_cfg;
   logic [IDX_W-1:0] h_index;

   assign h_cfg = h_sel_ff ? cfg2_ff : cfg1_ff;

   cht_hash #(.IDX_W(IDX_W), .TABLE_SIZE(TABLE_SIZE)) u_hash (
      .clock(clock), .reset(reset), .start(h_start), .cfg(h_cfg),
      .key(cur_ff), .done(h_done), .index(h_index)
   );

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      cur_in = cur_ff;
      round_in = round_ff;
      i1_in = i1_ff;
      i2_in = i2_ff;
      hit1_in = hit1_ff;
      clr_in = clr_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      h_sel_in = h_sel_ff;
      h_start = 1'b0;
      rd_addr = i1_ff;
      wr_en = 1'b0;
      wr_addr = i1_ff;
      wr_data = '0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff[IDX_W-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (IDX_W+1)'(TABLE_SIZE - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               kind_in = req_data.kind;
               cur_in = req_data.key;
               round_in = '0;
               rsp_in = '0;
               if (req_data.kind == cht_pkg::KIND_NOP) begin
                  state_in = S_RESP;
               end else begin
                  h_sel_in = 1'b0;
                  state_in = S_HSTART;
               end
            end
         end
         S_HSTART: begin
            h_start = 1'b1;
            state_in = h_sel_ff ? S_H2 : S_H1;
         end
         S_H1: begin
            if (h_done) begin
               i1_in = h_index;
               h_sel_in = 1'b1;
               state_in = S_HSTART;
            end
         end
         S_H2: begin
            if (h_done) begin
               i2_in = h_index;
               state_in = S_RD1;
            end
         end
         S_RD1: begin
            rd_addr = i1_ff;
            state_in = S_CHK1;
         end
         S_CHK1: begin
            hit1_in = rd_ff[KW] && rd_ff[KW-1:0] == cur_ff;
            rd_addr = i2_ff;
            if (kind_ff == cht_pkg::KIND_INSERT && !rd_ff[KW]) begin
               wr_en = 1'b1;
               wr_addr = i1_ff;
               wr_data = {1'b1, cur_ff};
               state_in = S_RESP;
            end else if (kind_ff == cht_pkg::KIND_REMOVE && hit1_in) begin
               wr_en = 1'b1;
               wr_addr = i1_ff;
               wr_data = '0;
               rsp_in.found = 1'b1;
               state_in = S_RESP;
            end else begin
               state_in = S_RD2;
            end
         end
         S_RD2: begin
            rd_addr = i2_ff;
            state_in = S_CHK2;
         end
         S_CHK2: begin
            wr_addr = i2_ff;
            unique case (kind_ff)
               cht_pkg::KIND_INSERT: begin
                  wr_en = 1'b1;
                  wr_data = {1'b1, cur_ff};
                  if (!rd_ff[KW]) begin
                     state_in = S_RESP;
                  end else begin
                     cur_in = rd_ff[KW-1:0];
                     if (round_ff == {1'b0, kicks_ff}) begin
                        rsp_in.status = 1'b1;
                        rsp_in.leftover_key = rd_ff[KW-1:0];
                        state_in = S_RESP;
                     end else begin
                        round_in = round_ff + 1'b1;
                        h_sel_in = 1'b0;
                        state_in = S_HSTART;
                     end
                  end
               end
               cht_pkg::KIND_LOOKUP: begin
                  rsp_in.found = hit1_ff || (rd_ff[KW] && rd_ff[KW-1:0] == cur_ff);
                  state_in = S_RESP;
               end
               default: begin
                  if (rd_ff[KW] && rd_ff[KW-1:0] == cur_ff) begin
                     wr_en = 1'b1;
                     wr_data = '0;
                     rsp_in.found = 1'b1;
                  end
                  state_in = S_RESP;
               end
            endcase
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = S_WAITR;
         end
         S_WAITR: begin
            if (!rsp_valid_in) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         h_sel_ff <= 1'b0;
         cfg1_ff <= '{mult: 17'd1, offset: 17'd0, prime: 17'd99551};
         cfg2_ff <= '{mult: 17'd3, offset: 17'd7, prime: 17'd99559};
         kicks_ff <= 6'd20;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         h_sel_ff <= h_sel_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               cht_pkg::CSR_MULT_ONE:   cfg1_ff.mult <= csr_data[cht_pkg::H_W-1:0];
               cht_pkg::CSR_OFFSET_ONE: cfg1_ff.offset <= csr_data[cht_pkg::H_W-1:0];
               cht_pkg::CSR_PRIME_ONE:  cfg1_ff.prime <= csr_data[cht_pkg::H_W-1:0];
               cht_pkg::CSR_MULT_TWO:   cfg2_ff.mult <= csr_data[cht_pkg::H_W-1:0];
               cht_pkg::CSR_OFFSET_TWO: cfg2_ff.offset <= csr_data[cht_pkg::H_W-1:0];
               cht_pkg::CSR_PRIME_TWO:  cfg2_ff.prime <= csr_data[cht_pkg::H_W-1:0];
               cht_pkg::CSR_MAX_KICKS:  kicks_ff <= csr_data[cht_pkg::KICK_W-1:0];
               default: ;
            endcase
         end
      end
      kind_ff <= kind_in;
      cur_ff <= cur_in;
      round_ff <= round_in;
      i1_ff <= i1_in;
      i2_ff <= i2_in;
      hit1_ff <= hit1_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff != S_IDLE)
      else $error("accepted item not started");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_WAITR || state_ff == S_IDLE)
      else $error("result shown while busy");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> req_stall)
      else $error("item taken during clearing pass");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.found == 1'b0)
      else $error("failed insert reports found");
endmodule

// ===== rtl/cht_hash.sv =====
`timescale 1ns / 1ps
// Computes ((mult*key+offset) mod prime) mod TABLE_SIZE. One remainder bit per cycle;
// when TABLE_SIZE is not a power of two a second pass divides by TABLE_SIZE.
module cht_hash #(
   parameter int IDX_W = 10,
   parameter int TABLE_SIZE = 1024
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  cht_pkg::hash_cfg_type cfg,
   input  logic [cht_pkg::KEY_W-1:0] key,
   output logic done,
   output logic [IDX_W-1:0] index
);
   localparam int PW = cht_pkg::KEY_W + cht_pkg::H_W + 1;
   localparam int CW = $clog2(PW + 1);
   localparam bit POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MUL  = 3'b010,
      S_DIV  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [PW-1:0] val_ff, val_in;
   logic [cht_pkg::H_W:0] rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [cht_pkg::H_W-1:0] div_ff, div_in;
   logic last_ff, last_in;
   logic [cht_pkg::H_W:0] shifted;
   logic [cht_pkg::H_W:0] step_rem;
   logic done_ff, done_in;
   logic [IDX_W-1:0] index_ff, index_in;

   always_comb begin
      state_in = state_ff;
      val_in = val_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      div_in = div_ff;
      last_in = last_ff;
      done_in = 1'b0;
      index_in = index_ff;
      shifted = {rem_ff[cht_pkg::H_W-1:0], val_ff[PW-1]};
      if (shifted >= {1'b0, div_ff}) begin
         step_rem = shifted - {1'b0, div_ff};
      end else begin
         step_rem = shifted;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in = PW'(cfg.mult) * PW'(key);
               div_in = cfg.prime;
               last_in = POW2;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            val_in = val_ff + PW'(cfg.offset);
            rem_in = '0;
            cnt_in = CW'(PW);
            if (div_ff == '0) begin
               if (POW2) begin
                  index_in = IDX_W'(val_in);
                  done_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  div_in = cht_pkg::H_W'(TABLE_SIZE);
                  last_in = 1'b1;
                  state_in = S_DIV;
               end
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            val_in = {val_ff[PW-2:0], 1'b0};
            rem_in = step_rem;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               if (last_ff) begin
                  index_in = IDX_W'(step_rem);
                  done_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  val_in = {step_rem[cht_pkg::H_W-1:0], {(PW-cht_pkg::H_W){1'b0}}};
                  rem_in = '0;
                  cnt_in = CW'(cht_pkg::H_W);
                  div_in = cht_pkg::H_W'(TABLE_SIZE);
                  last_in = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      val_ff <= val_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      last_ff <= last_in;
      index_ff <= index_in;
   end

   assign done = done_ff;
   assign index = index_ff;

   assert property (@(posedge clock) disable iff (reset) done |-> $past(state_ff) != S_IDLE)
      else $error("hash done without work");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff != '0)
      else $error("divider count underflow");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < {1'b0, div_ff})
      else $error("remainder out of range");
endmodule
